// ===== sv/dwt53_pkg.sv =====
// shared types, constants and the window-select function of the inverse 5/3 lifting block
// no dependencies; used by dwt53_sample, dwt53_ofifo and inverse_dwt53_lifting
package dwt53_pkg;

    typedef enum logic {
        PAR_EVEN = 1'b0,
        PAR_ODD  = 1'b1
    } t_parity;

    // line position saturates here, window holds four older coefficients plus the new one
    localparam int POS_W   = 3;
    localparam int WIN_N   = 5;
    localparam int WIN_W   = 3;
    localparam logic [POS_W-1:0] POS_MAX = 3'd4;

    // result slots per item and output queue geometry
    localparam int SLOT_N     = 3;
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = 2;
    localparam int OQ_CNT_W   = 3;
    localparam int PUSH_W     = 2;

    // configuration space
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_START_PARITY = 3'd0;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [WIN_W-1:0] t_win_idx;

    // maps a line index (relative to the current position kk) to a window slot,
    // with whole-sample symmetric extension at both line ends when the line closes
    function automatic t_win_idx win_sel(input t_pos kk, input logic signed [4:0] idx,
                                         input logic lst);
        logic signed [4:0] m;
        logic signed [4:0] kks;
        logic signed [4:0] b;
        m   = idx;
        kks = signed'({2'b00, kk});
        if (lst) begin
            for (int r = 0; r < 2; r++) begin
                if (m < 0) begin
                    m = -m;
                end
                if (m > kks) begin
                    m = (kks <<< 1) - m;
                end
            end
        end else if (m < 0) begin
            m = -m;
        end
        b = m - kks + 5'sd4;
        if (b < 0) begin
            b = 5'sd0;
        end
        if (b > 5'sd4) begin
            b = 5'sd4;
        end
        return b[WIN_W-1:0];
    endfunction

endpackage

// ===== sv/inverse_dwt53_lifting.sv =====
// top level of the inverse reversible 5/3 lifting block: window, stage register, queue
// depends on dwt53_pkg, dwt53_sample and dwt53_ofifo
// a coefficient is registered in the stage register at its transfer; its samples enter the
//   output queue when the stage advances and can then transfer on the master side
// throughput: 1 coefficient per cycle, stalling only while the queue lacks room for every sample
//   of the staged one (up to 3 at a line end); reset: sync, active low, clears control state
module inverse_dwt53_lifting #(
    parameter int COEF_BITS = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // coefficient stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [((COEF_BITS+7)/8)*8-1:0] s_axis_tdata,   // [COEF_BITS-1:0] coefficient
    input  logic                  s_axis_tlast,            // is_last
    // sample stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [((COEF_BITS+7)/8)*8-1:0] m_axis_tdata,   // [COEF_BITS-1:0] sample
    output logic                  m_axis_tlast,            // last
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [dwt53_pkg::PADDR_W-1:0] paddr,
    input  logic [dwt53_pkg::PDATA_W-1:0] pwdata,
    output logic [dwt53_pkg::PDATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int TDATA_W = ((COEF_BITS + 7) / 8) * 8;
    localparam int RES_W   = COEF_BITS + 1;    // sample plus last flag

    // ---------------------------------------------------------------- configuration
    logic w_cfg_hit;
    logic r_start_parity;

    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[dwt53_pkg::PADDR_W-1:2]
                        == dwt53_pkg::ADDR_START_PARITY[dwt53_pkg::PADDR_W-1:2]);
    assign prdata    = w_cfg_hit ? dwt53_pkg::PDATA_W'(r_start_parity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_parity <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_cfg_hit) begin
            r_start_parity <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------- line state
    logic signed [COEF_BITS-1:0] r_win [4];         // last four coefficients, oldest first
    dwt53_pkg::t_pos             r_pos;             // index within line, saturating
    logic [1:0]                  r_pc;              // samples held back, 0..2
    dwt53_pkg::t_parity          r_next_par;
    dwt53_pkg::t_parity          w_cur_par;
    logic signed [COEF_BITS-1:0] w_coef;
    logic                        w_in_xfer;

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;
    assign w_coef    = signed'(s_axis_tdata[COEF_BITS-1:0]);
    // parity comes from the register only at line start, so a mid-line write waits
    assign w_cur_par = (r_pos == '0) ? dwt53_pkg::t_parity'(r_start_parity) : r_next_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= '0;
            end
            r_pos      <= '0;
            r_pc       <= '0;
            r_next_par <= dwt53_pkg::PAR_EVEN;
        end else if (w_in_xfer) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[3] <= w_coef;
            if (s_axis_tlast) begin
                r_pos      <= '0;
                r_pc       <= '0;
                r_next_par <= dwt53_pkg::PAR_EVEN;
            end else begin
                if (r_pos < dwt53_pkg::POS_MAX) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (r_pc < 2'd2) begin
                    r_pc <= r_pc + 1'b1;
                end
                r_next_par <= dwt53_pkg::t_parity'(~w_cur_par);
            end
        end
    end

    // ---------------------------------------------------------------- stage register
    logic                        r_vld;
    logic signed [COEF_BITS-1:0] r_c [dwt53_pkg::WIN_N];   // window plus current coefficient
    dwt53_pkg::t_pos             r_kk;
    logic [1:0]                  r_spc;
    dwt53_pkg::t_parity          r_par;
    logic                        r_last;
    logic                        w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_in_xfer) begin
            r_vld <= 1'b1;
        end else if (w_advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            for (int i = 0; i < 4; i++) begin
                r_c[i] <= r_win[i];
            end
            r_c[4] <= w_coef;
            r_kk   <= r_pos;
            r_spc  <= r_pc;
            r_par  <= w_cur_par;
            r_last <= s_axis_tlast;
        end
    end

    // ---------------------------------------------------------------- sample slots
    // slot s reconstructs line index kk - pc + s; a plain coefficient only fills slot 0
    logic signed [COEF_BITS-1:0] w_v [dwt53_pkg::SLOT_N][dwt53_pkg::WIN_N];
    dwt53_pkg::t_parity          w_spar [dwt53_pkg::SLOT_N];
    logic        [COEF_BITS-1:0] w_smp [dwt53_pkg::SLOT_N];

    always_comb begin
        for (int s = 0; s < dwt53_pkg::SLOT_N; s++) begin
            for (int d = 0; d < dwt53_pkg::WIN_N; d++) begin
                w_v[s][d] = r_c[dwt53_pkg::win_sel(r_kk,
                                5'(int'(r_kk) - int'(r_spc) + s + d - 2), r_last)];
            end
            w_spar[s] = dwt53_pkg::t_parity'(r_par ^ r_spc[0] ^ s[0]);
        end
    end

    for (genvar g = 0; g < dwt53_pkg::SLOT_N; g++) begin : g_slot
        dwt53_sample #(
            .COEF_BITS (COEF_BITS)
        ) u_sample (
            .i_v      (w_v[g]),
            .i_par    (w_spar[g]),
            .o_sample (w_smp[g])
        );
    end

    // one-sample line: pass at even start, halve toward zero at odd start
    logic                        w_single;
    logic signed [COEF_BITS:0]   w_half;

    assign w_single = r_last && (r_kk == '0);
    assign w_half   = (COEF_BITS + 1)'(r_c[4]) + (COEF_BITS + 1)'(r_c[4][COEF_BITS-1]);

    // ---------------------------------------------------------------- queue push
    logic [dwt53_pkg::PUSH_W-1:0]   w_nres;
    logic [RES_W-1:0]               w_push_data [dwt53_pkg::SLOT_N];
    logic [dwt53_pkg::PUSH_W-1:0]   w_push_n;
    logic [dwt53_pkg::OQ_CNT_W-1:0] w_free;
    logic [RES_W-1:0]               w_out;

    always_comb begin
        if (w_single) begin
            w_nres = 2'd1;
        end else if (r_last) begin
            w_nres = r_spc + 2'd1;
        end else begin
            w_nres = (r_spc == 2'd2) ? 2'd1 : 2'd0;
        end
        for (int s = 0; s < dwt53_pkg::SLOT_N; s++) begin
            w_push_data[s] = {r_last && (2'(s) == r_spc), w_smp[s]};
        end
        if (w_single) begin
            if (r_par == dwt53_pkg::PAR_EVEN) begin
                w_push_data[0] = {1'b1, r_c[4]};
            end else begin
                w_push_data[0] = {1'b1, w_half[COEF_BITS:1]};
            end
        end
    end

    // the stage moves on only when the queue has room for every result of its item
    assign w_advance     = r_vld && (w_free >= dwt53_pkg::OQ_CNT_W'(w_nres));
    assign w_push_n      = w_advance ? w_nres : 2'd0;
    assign s_axis_tready = !r_vld || w_advance;

    dwt53_ofifo #(
        .DATA_W (RES_W)
    ) u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (w_push_n),
        .i_push_data (w_push_data),
        .o_free      (w_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = TDATA_W'(w_out[COEF_BITS-1:0]);
    assign m_axis_tlast = w_out[COEF_BITS];

    // ---------------------------------------------------------------- checks
    // held-back count follows line position up to two
    a_pc_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pos >= 3'd2) ? (r_pc == 2'd2) : (r_pc == r_pos[1:0])))
        else $error("held-back count out of step with line position");

    // a line-end transfer returns the line state to its start
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && s_axis_tlast) |=> (r_pos == '0 && r_pc == 2'd0))
        else $error("line state not cleared after last coefficient");

    // a stalled stage keeps its item
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !w_advance) |=> (r_vld && $stable(r_c[4]) && $stable(r_last)))
        else $error("stage item lost while waiting for queue room");

endmodule

// ===== sv/dwt53_sample.sv =====
// one reconstructed sample from five neighboring coefficients, 5/3 reversible lifting
// depends on dwt53_pkg (parity type)
module dwt53_sample #(
    parameter int COEF_BITS = 18
) (
    input  logic signed [COEF_BITS-1:0] i_v [dwt53_pkg::WIN_N],   // neighbors j-2 .. j+2
    input  dwt53_pkg::t_parity          i_par,
    output logic        [COEF_BITS-1:0] o_sample
);

    localparam int SW = COEF_BITS + 3;
    localparam logic signed [SW-1:0] TWO  = SW'(2);
    localparam logic signed [SW-1:0] MAXV = SW'((64'd1 << (COEF_BITS - 1)) - 64'd1);
    localparam logic signed [SW-1:0] MINV = -MAXV - TWO + SW'(1);

    logic signed [SW-1:0] x [dwt53_pkg::WIN_N];
    logic signed [SW-1:0] e_m1, e_0, e_p1, odd_v, res;

    always_comb begin
        for (int d = 0; d < dwt53_pkg::WIN_N; d++) begin
            x[d] = SW'(i_v[d]);
        end
    end

    // even update: low minus floor((left + right + 2) / 4)
    assign e_m1 = x[1] - ((x[0] + x[2] + TWO) >>> 2);
    assign e_0  = x[2] - ((x[1] + x[3] + TWO) >>> 2);
    assign e_p1 = x[3] - ((x[2] + x[4] + TWO) >>> 2);

    // odd update: high plus floor((even left + even right) / 2)
    assign odd_v = x[2] + ((e_m1 + e_p1) >>> 1);

    assign res = (i_par == dwt53_pkg::PAR_EVEN) ? e_0 : odd_v;

    always_comb begin
        if (res > MAXV) begin
            o_sample = MAXV[COEF_BITS-1:0];
        end else if (res < MINV) begin
            o_sample = MINV[COEF_BITS-1:0];
        end else begin
            o_sample = res[COEF_BITS-1:0];
        end
    end

endmodule

// ===== sv/dwt53_ofifo.sv =====
// small output queue, up to three pushes and one pop per cycle
// depends on dwt53_pkg (depth and pointer widths)
module dwt53_ofifo #(
    parameter int DATA_W = 19
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [dwt53_pkg::PUSH_W-1:0]    i_push_n,
    input  logic [DATA_W-1:0]               i_push_data [dwt53_pkg::SLOT_N],
    output logic [dwt53_pkg::OQ_CNT_W-1:0]  o_free,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [DATA_W-1:0]               o_data
);

    logic [DATA_W-1:0]               r_mem [dwt53_pkg::OQ_DEPTH];
    logic [dwt53_pkg::OQ_PTR_W-1:0]  r_wr, r_rd;
    logic [dwt53_pkg::OQ_CNT_W-1:0]  r_cnt;
    logic                            w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_free  = dwt53_pkg::OQ_CNT_W'(dwt53_pkg::OQ_DEPTH) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + dwt53_pkg::OQ_PTR_W'(i_push_n);
            r_rd  <= r_rd + dwt53_pkg::OQ_PTR_W'(w_pop);
            r_cnt <= r_cnt + dwt53_pkg::OQ_CNT_W'(i_push_n)
                     - dwt53_pkg::OQ_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < dwt53_pkg::SLOT_N; k++) begin
            if (dwt53_pkg::PUSH_W'(k) < i_push_n) begin
                r_mem[r_wr + dwt53_pkg::OQ_PTR_W'(k)] <= i_push_data[k];
            end
        end
    end

endmodule

// ===== tb/dwt53_line_checker.sv =====
`timescale 1ns / 1ps
// checker for the inverse 5/3 lifting block: watches the coefficient, sample and apb channels,
// predicts every sample of a line and compares it with the sample transfers
// depends on dwt53_pkg for the parity type and the register address
module dwt53_line_checker #(
    parameter int COEF_BITS = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_coef_tvalid,
    input  logic                           i_coef_tready,
    input  logic [((COEF_BITS+7)/8)*8-1:0] i_coef_tdata,   // [COEF_BITS-1:0] coefficient
    input  logic                           i_coef_tlast,   // is_last
    input  logic                           i_smp_tvalid,
    input  logic                           i_smp_tready,
    input  logic [((COEF_BITS+7)/8)*8-1:0] i_smp_tdata,    // [COEF_BITS-1:0] sample
    input  logic                           i_smp_tlast,    // last
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [dwt53_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [dwt53_pkg::PDATA_W-1:0]  i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [COEF_BITS-1:0] smp;
        logic                 eol;
    } t_smp_xfer;

    t_smp_xfer expected_samples[$];
    t_smp_xfer want;

    // line state
    dwt53_pkg::t_parity line_start_parity;
    dwt53_pkg::t_parity next_par;
    longint  coef_hist[4];
    int      line_pos;
    int      held_count;

    // view of the line around the current coefficient
    longint  view_coef[5];
    int      view_kk;
    logic    view_closing;

    // whole-sample symmetric extension; mirrors at both ends once the line closes
    function automatic longint view_fetch(input int idx);
        int p;
        int m;
        int b;
        if (view_closing) begin
            p = 2 * view_kk;
            if (p <= 0) begin
                p = 1;
            end
            m = idx % p;
            if (m < 0) begin
                m += p;
            end
            if (m > view_kk) begin
                m = p - m;
            end
            idx = m;
        end else if (idx < 0) begin
            idx = -idx;
        end
        b = idx - view_kk + 4;
        if (b < 0) begin
            b = 0;
        end
        if (b > 4) begin
            b = 4;
        end
        return view_coef[b];
    endfunction

    function automatic longint even_sample(input int i);
        return view_fetch(i) - ((view_fetch(i - 1) + view_fetch(i + 1) + 2) >>> 2);
    endfunction

    function automatic longint recon_sample(input int j, input dwt53_pkg::t_parity cur_par);
        logic odd_pos;
        odd_pos = (cur_par == dwt53_pkg::PAR_ODD) ^ (((view_kk - j) % 2) != 0);
        if (!odd_pos) begin
            return even_sample(j);
        end
        return view_fetch(j) + ((even_sample(j - 1) + even_sample(j + 1)) >>> 1);
    endfunction

    task automatic queue_sample(input longint v, input logic eol);
        longint    hi;
        longint    lo;
        t_smp_xfer item;
        hi = (longint'(1) << (COEF_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        item.smp = v[COEF_BITS-1:0];
        item.eol = eol;
        expected_samples.push_back(item);
    endtask

    task automatic predict_coef(input longint coef, input logic closing);
        dwt53_pkg::t_parity cur_par;
        cur_par = (line_pos == 0) ? line_start_parity : next_par;
        for (int i = 0; i < 4; i++) begin
            view_coef[i] = coef_hist[i];
        end
        view_coef[4] = coef;
        view_kk      = (line_pos > 4) ? 4 : line_pos;
        view_closing = closing;
        if (closing) begin
            if (view_kk == 0) begin
                // single-coefficient line: as is at even index, halved toward zero at odd
                queue_sample((cur_par == dwt53_pkg::PAR_EVEN) ? coef : coef / 2, 1'b1);
            end else begin
                for (int j = view_kk - held_count; j <= view_kk; j++) begin
                    queue_sample(recon_sample(j, cur_par), j == view_kk);
                end
            end
            line_pos   = 0;
            held_count = 0;
            next_par   = dwt53_pkg::PAR_EVEN;
        end else begin
            if (held_count >= 2) begin
                queue_sample(recon_sample(view_kk - 2, cur_par), 1'b0);
            end else begin
                held_count++;
            end
            if (line_pos < 4) begin
                line_pos++;
            end
            next_par = dwt53_pkg::t_parity'(~cur_par);
        end
        coef_hist[0] = coef_hist[1];
        coef_hist[1] = coef_hist[2];
        coef_hist[2] = coef_hist[3];
        coef_hist[3] = coef;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_start_parity = dwt53_pkg::PAR_EVEN;
            next_par          = dwt53_pkg::PAR_EVEN;
            line_pos          = 0;
            held_count        = 0;
            for (int i = 0; i < 4; i++) begin
                coef_hist[i] = 0;
            end
            expected_samples.delete();
        end else begin
            if (i_smp_tvalid && i_smp_tready) begin
                if (expected_samples.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected sample transfer, expected none, actual %h last %b",
                             $time, i_smp_tdata[COEF_BITS-1:0], i_smp_tlast);
                end else begin
                    want = expected_samples.pop_front();
                    if (i_smp_tdata[COEF_BITS-1:0] !== want.smp
                        || i_smp_tlast !== want.eol) begin
                        o_fail_count++;
                        $display("%0t: sample mismatch, expected %h last %b, actual %h last %b",
                                 $time, want.smp, want.eol, i_smp_tdata[COEF_BITS-1:0],
                                 i_smp_tlast);
                    end
                end
            end
            if (i_coef_tvalid && i_coef_tready) begin
                predict_coef(longint'(signed'(i_coef_tdata[COEF_BITS-1:0])), i_coef_tlast);
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == dwt53_pkg::ADDR_START_PARITY) begin
                line_start_parity = dwt53_pkg::t_parity'(i_pwdata[0]);
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// ===== tb/inverse_dwt53_lifting_tb.sv =====
`timescale 1ns / 1ps
// testbench top of the inverse 5/3 lifting block: clock, reset, coefficient lines, sink stalls
// and apb writes of start_parity; depends on dwt53_pkg, inverse_dwt53_lifting, dwt53_line_checker
module inverse_dwt53_lifting_tb;

    localparam int COEF_BITS     = 18;
    localparam int DATA_W        = ((COEF_BITS + 7) / 8) * 8;
    localparam int COEF_MAX      = (1 << (COEF_BITS - 1)) - 1;
    localparam int COEF_MIN      = -(1 << (COEF_BITS - 1));
    // extra settle time after all expected samples have drained
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 80;
    localparam int PHASE_ITEMS   = 100;
    localparam int LIMIT_CYCLES  = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;    // [17:0] coefficient, upper bits ignored
    logic              s_axis_tlast;    // is_last
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;    // [17:0] sample
    logic              m_axis_tlast;    // last
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [dwt53_pkg::PADDR_W-1:0] paddr;
    logic [dwt53_pkg::PDATA_W-1:0] pwdata;
    logic [dwt53_pkg::PDATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending_samples;
    int   cycle_count;
    int   burst_left;
    int   coef_sent;
    logic steady_sender;    // no gaps between transfers while set
    logic hold_req;         // asks the sink for its one long hold-off

    inverse_dwt53_lifting #(
        .COEF_BITS(COEF_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dwt53_line_checker #(
        .COEF_BITS(COEF_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coef_tvalid (s_axis_tvalid),
        .i_coef_tready (s_axis_tready),
        .i_coef_tdata  (s_axis_tdata),
        .i_coef_tlast  (s_axis_tlast),
        .i_smp_tvalid  (m_axis_tvalid),
        .i_smp_tready  (m_axis_tready),
        .i_smp_tdata   (m_axis_tdata),
        .i_smp_tlast   (m_axis_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_samples)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: ends a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("inverse_dwt53_lifting_tb: FAIL");
        $finish;
    end

    // sink side: segments of steady, random and patterned ready, plus one long hold-off
    initial begin : sample_sink
        int   seg_left;
        int   mode;
        int   hold_left;
        logic hold_done;
        seg_left      = 0;
        mode          = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                // sender keeps offering, so the output queue fills and the slave side stalls
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_axis_tready <= (seg_left % 3 == 0);
                    end
                endcase
            end
        end
    end

    // one coefficient transfer, with a random gap at the start of each burst unless the sender is steady
    task automatic send_coef(input int coef, input logic eol);
        logic [DATA_W-1:0] word;
        word                  = DATA_W'($urandom);
        word[COEF_BITS-1:0]   = COEF_BITS'(coef);
        if (burst_left == 0) begin
            if (!steady_sender) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        coef_sent++;
    endtask

    // line of alternating values, last one flagged
    task automatic send_alt_line(input int len, input int first, input int second);
        for (int k = 0; k < len; k++) begin
            send_coef((k % 2 == 0) ? first : second, k == len - 1);
        end
    endtask

    function automatic int pick_coef();
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            2, 3, 4: begin
                return int'($urandom_range(0, 256)) - 128;
            end
            default: begin
                return int'($urandom);
            end
        endcase
    endfunction

    // mostly short lines, some medium, a few long ones
    task automatic send_random_line();
        int r;
        int len;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            len = $urandom_range(1, 8);
        end else if (r < 19) begin
            len = $urandom_range(9, 24);
        end else begin
            len = $urandom_range(25, 60);
        end
        for (int k = 0; k < len; k++) begin
            send_coef(pick_coef(), k == len - 1);
        end
    endtask

    // quiet the slave side, let every expected sample drain, then write start_parity
    task automatic settle_and_write(input dwt53_pkg::t_parity par);
        logic [dwt53_pkg::PDATA_W-1:0] data;
        data          = $urandom;
        data[0]       = par;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_samples != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        // setup cycle, then access cycle
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dwt53_pkg::ADDR_START_PARITY;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        steady_sender = 1'b0;
        burst_left    = 0;
        coef_sent     = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, start_parity at its reset value (even)
        send_alt_line(1, COEF_MAX, 0);              // one-sample line passes through
        send_alt_line(1, COEF_MIN, 0);
        send_alt_line(2, COEF_MIN, COEF_MAX);
        send_alt_line(5, COEF_MAX, COEF_MIN);       // even samples overflow and saturate
        send_alt_line(4, COEF_MIN, COEF_MAX);

        // directed, odd start
        settle_and_write(dwt53_pkg::PAR_ODD);
        send_alt_line(1, COEF_MIN + 1, 0);          // one-sample line halved toward zero
        send_alt_line(1, COEF_MAX, 0);
        send_alt_line(1, -1, 0);
        send_alt_line(3, COEF_MAX, COEF_MIN);

        // register change in mid-line only applies to the next line
        send_coef(5, 1'b0);
        send_coef(-7, 1'b0);
        settle_and_write(dwt53_pkg::PAR_EVEN);
        send_coef(100000, 1'b0);
        send_coef(-3, 1'b1);

        // random lines, alternating start parity per phase, one phase without sender gaps
        for (int ph = 0; ph < 4; ph++) begin
            settle_and_write((ph % 2 == 0) ? dwt53_pkg::PAR_ODD : dwt53_pkg::PAR_EVEN);
            // long sink hold-off while the sender keeps offering coefficients
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            steady_sender = (ph == 2);
            coef_sent     = 0;
            while (coef_sent < PHASE_ITEMS) begin
                send_random_line();
            end
        end

        // drain and verdict
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_samples != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("inverse_dwt53_lifting_tb: PASS");
        end else begin
            $display("inverse_dwt53_lifting_tb: FAIL");
        end
        $finish;
    end

endmodule
